// File: rtl/core/f2p_pkg.sv
package f2p_pkg;

    localparam int SAMPLE_W = 32;
    localparam int PCM_W = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_INPUT_IS_FLOAT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_IS_MONO = 1'd1;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_word;
        logic                frame_end;
    } in_item_t;

    typedef struct packed {
        logic signed [PCM_W-1:0] pcm_sample;
        logic                    right_channel;
        logic                    last_of_run;
        logic                    frame_done;
    } out_item_t;

    // Classified request passed from the front part to the back part.
    typedef struct packed {
        logic signed [PCM_W-1:0] pcm;
        logic                    mono;
        logic                    frame_end;
    } job_t;

endpackage

// File: rtl/core/f2p_if.sv
interface f2p_in_if;
    import f2p_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface f2p_out_if;
    import f2p_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/f2p_front.sv
module f2p_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  f2p_pkg::in_item_t       in_data,
    input  logic                    is_float,
    input  logic                    is_mono,
    output logic                    job_valid,
    input  logic                    job_ready,
    output f2p_pkg::job_t           job
);
    import f2p_pkg::*;

    // Single-precision multiply by 32767 with round-to-nearest-even, then
    // truncation toward zero to int32 with saturation; low 16 bits kept.
    function automatic logic [PCM_W-1:0] conv(input logic [31:0] w);
        logic        s;
        logic [7:0]  e;
        logic [23:0] m;
        logic [39:0] prod;
        logic [24:0] mant;
        logic        g;
        logic        st;
        logic [9:0]  pe;
        logic [25:0] rm;
        logic [31:0] mag;
        logic [31:0] res;
        s = w[31];
        e = w[30:23];
        m = {(e != 8'd0), w[22:0]};
        res = 32'd0;
        if (e == 8'hFF) begin
            if (w[22:0] != 23'd0)
                res = 32'd0;
            else
                res = s ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else if (e != 8'd0) begin
            prod = {16'd0, m} * 40'd32767;
            // prod < 2^39; bit 38 set or not
            if (prod[38]) begin
                mant = {1'b0, prod[38:15]};
                g = prod[14];
                st = |prod[13:0];
                pe = {2'd0, e} + 10'd15;
            end else begin
                mant = {1'b0, prod[37:14]};
                g = prod[13];
                st = |prod[12:0];
                pe = {2'd0, e} + 10'd14;
            end
            rm = {1'b0, mant} + {25'd0, g & (st | mant[0])};
            if (rm[24]) begin
                rm = rm >> 1;
                pe = pe + 10'd1;
            end
            // value = rm[23:0] * 2^(pe-127-23)
            if (pe >= 10'd158) begin
                res = s ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else if (pe < 10'd127) begin
                res = 32'd0;
            end else begin
                if (pe >= 10'd150)
                    mag = {8'd0, rm[23:0]} << (pe - 10'd150);
                else
                    mag = {8'd0, rm[23:0]} >> (10'd150 - pe);
                res = s ? (32'd0 - mag) : mag;
            end
        end
        return res[PCM_W-1:0];
    endfunction

    always_comb
    begin
        in_ready = !job_valid || job_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid <= 1'b0;
        end
        else if (in_ready)
        begin
            job_valid <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            job.pcm <= is_float ? conv(in_data.sample_word)
                                : in_data.sample_word[PCM_W-1:0];
            job.mono <= is_mono;
            job.frame_end <= in_data.frame_end;
        end
    end
endmodule

// File: rtl/core/f2p_queue.sv
module f2p_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  f2p_pkg::job_t wr_data,
    output logic          rd_valid,
    input  logic          rd_ready,
    output f2p_pkg::job_t rd_data
);
    import f2p_pkg::*;

    job_t       mem_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_valid && wr_ready)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr_valid && wr_ready)
                wp_reg <= !wp_reg;
            if (rd_valid && rd_ready)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr_valid && wr_ready}
                               - {1'b0, rd_valid && rd_ready};
        end
    end
endmodule

// File: rtl/core/f2p_back.sv
module f2p_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  job_valid,
    output logic                  job_ready,
    input  f2p_pkg::job_t         job,
    output logic                  out_valid,
    input  logic                  out_ready,
    output f2p_pkg::out_item_t    out_data
);
    import f2p_pkg::*;

    logic second_reg;
    logic load;

    assign load = !out_valid || out_ready;
    // The job is consumed when its final result is loaded.
    assign job_ready = load && (!job.mono || second_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
            second_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid <= job_valid;
            if (job_valid && job.mono)
                second_reg <= !second_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && job_valid)
        begin
            out_data.pcm_sample <= job.pcm;
            out_data.right_channel <= job.mono && second_reg;
            out_data.last_of_run <= !job.mono || second_reg;
            out_data.frame_done <= job.frame_end && (!job.mono || second_reg);
        end
    end
endmodule

// File: rtl/core/float_to_pcm16_mono_stereo.sv
// The front part registers each input request, a two-entry queue holds it and the back
// part registers each result. Throughput: one input per cycle in stereo mode while out_ch
// is not stalled; in mono mode it is limited by the single output port of the back part.
// Reset: asynchronous active-low rst_n clears all valid state; input_is_float
// resets to 1 and input_is_mono to 0.
module float_to_pcm16_mono_stereo (
    input  logic                           clk,
    input  logic                           rst_n,
    f2p_in_if.sink                         in_ch,
    f2p_out_if.source                      out_ch,
    input  logic                           cfg_we,
    input  logic [f2p_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [f2p_pkg::CFG_DATA_W-1:0] cfg_data
);
    import f2p_pkg::*;

    logic is_float_reg;
    logic is_mono_reg;
    logic f_valid;
    logic f_ready;
    job_t f_job;
    logic q_valid;
    logic q_ready;
    job_t q_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            is_float_reg <= 1'b1;
            is_mono_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_INPUT_IS_FLOAT: is_float_reg <= cfg_data[0];
                REG_INPUT_IS_MONO: is_mono_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    f2p_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
        .is_float(is_float_reg), .is_mono(is_mono_reg),
        .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
    );

    f2p_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_job)
    );

    f2p_back u_back (
        .clk(clk), .rst_n(rst_n),
        .job_valid(q_valid), .job_ready(q_ready), .job(q_job),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
    );
endmodule

// File: rtl/core/f2p_checker.sv
module f2p_checker (
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_ready,
    input logic right_channel,
    input logic last_of_run,
    input logic frame_done
);
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> last_of_run)
        else $error("frame_done without last_of_run");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && right_channel |-> last_of_run)
        else $error("right copy is not last");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_run |=> out_valid && right_channel)
        else $error("left copy not followed by right copy");
endmodule

bind float_to_pcm16_mono_stereo f2p_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .right_channel(out_ch.data.right_channel),
    .last_of_run(out_ch.data.last_of_run),
    .frame_done(out_ch.data.frame_done)
);

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import f2p_pkg::*;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    f2p_in_if in_ch ();
    f2p_out_if out_ch ();

    float_to_pcm16_mono_stereo dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    logic mode_float;
    logic mode_mono;
    out_item_t pending_samples[$];
    int mismatch_count;
    int send_idle_pct;
    int recv_stall_pct;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

    // Scale by 32767 with single-precision rounding, truncate, saturate, keep 16 bits.
    function automatic logic [15:0] scale_float(logic [31:0] w);
        logic sgn;
        int ex;
        int n;
        int s;
        int e2;
        logic [63:0] m;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        logic [191:0] mag;
        logic [31:0] v;
        sgn = w[31];
        ex = int'(w[30:23]);
        if (ex == 255)
        begin
            if (w[22:0] != 0)
                return 16'h0000;
            return sgn ? 16'h0000 : 16'hFFFF;
        end
        m = {41'd0, w[22:0]};
        if (ex == 0)
            ex = 1;
        else
            m[23] = 1'b1;
        m = m * 64'd32767;
        if (m == 0)
            return 16'h0000;
        n = 0;
        for (int i = 0; i < 64; i++)
            if (m[i])
                n = i + 1;
        if (n > 24)
        begin
            s = n - 24;
            q = m >> s;
            rem = m & ((64'd1 << s) - 1);
            half = 64'd1 << (s - 1);
            if (rem > half || (rem == half && q[0]))
                q = q + 1;
            m = q << s;
        end
        e2 = ex - 150;
        mag = {128'd0, m};
        if (e2 >= 0)
            mag = mag << e2;
        else
            mag = mag >> (-e2);
        if (mag >= (192'd1 << 31))
            return sgn ? 16'h0000 : 16'hFFFF;
        v = sgn ? -mag[31:0] : mag[31:0];
        return v[15:0];
    endfunction

    task automatic queue_expected_samples(in_item_t item);
        out_item_t r;
        logic [15:0] pcm;
        pcm = mode_float ? scale_float(item.sample_word) : item.sample_word[15:0];
        r.pcm_sample = pcm;
        if (mode_mono)
        begin
            r.right_channel = 1'b0;
            r.last_of_run = 1'b0;
            r.frame_done = 1'b0;
            pending_samples.push_back(r);
            r.right_channel = 1'b1;
        end
        else
            r.right_channel = 1'b0;
        r.last_of_run = 1'b1;
        r.frame_done = item.frame_end;
        pending_samples.push_back(r);
    endtask

    task automatic send_sample(logic [31:0] word, logic fend);
        in_item_t item;
        item.sample_word = word;
        item.frame_end = fend;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= item;
        do
            @(posedge clk);
        while (!in_ch.ready);
        queue_expected_samples(item);
    endtask

    task automatic drain_samples();
        in_ch.valid <= 1'b0;
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic val);
        drain_samples();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_INPUT_IS_FLOAT)
            mode_float = val;
        else if (idx == REG_INPUT_IS_MONO)
            mode_mono = val;
        @(posedge clk);
    endtask

    function automatic logic [31:0] random_float_word();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(3))
            0: w[30:23] = 8'($urandom_range(140, 110));
            1: w[30:23] = 8'($urandom_range(127, 118));
            2: w[30:23] = 8'($urandom_range(160, 134));
            default: ;
        endcase
        return w;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (pending_samples.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected sample %h", out_ch.data);
                end
                else
                begin
                    out_item_t exp_s;
                    exp_s = pending_samples.pop_front();
                    if (out_ch.data !== exp_s)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: exp pcm=%h r=%b l=%b f=%b got pcm=%h r=%b l=%b f=%b",
                                exp_s.pcm_sample, exp_s.right_channel, exp_s.last_of_run,
                                exp_s.frame_done, out_ch.data.pcm_sample,
                                out_ch.data.right_channel, out_ch.data.last_of_run,
                                out_ch.data.frame_done);
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic test_float_extremes();
        logic [31:0] words[16] = '{32'h00000000, 32'h80000000, 32'h3F800000, 32'hBF800000,
            32'h3F000000, 32'h3F7FFFFF, 32'h40000000, 32'h47800000, 32'h501502F9,
            32'hD01502F9, 32'h7F800000, 32'hFF800000, 32'h7FC00000, 32'hFFFFFFFF,
            32'h00000001, 32'h7F7FFFFF};
        write_register(REG_INPUT_IS_FLOAT, 1'b1);
        write_register(REG_INPUT_IS_MONO, 1'b0);
        foreach (words[i])
            send_sample(words[i], i[0]);
        write_register(REG_INPUT_IS_MONO, 1'b1);
        send_sample(32'h3E800000, 1'b1);
        send_sample(32'hCF000000, 1'b0);
    endtask

    task automatic test_int16_passthrough();
        write_register(REG_INPUT_IS_FLOAT, 1'b0);
        send_sample(32'hFFFF8000, 1'b1);
        send_sample(32'h12347FFF, 1'b0);
        write_register(REG_INPUT_IS_MONO, 1'b0);
        send_sample(32'hABCD0000, 1'b1);
        send_sample(32'h0000FFFF, 1'b0);
        send_sample(32'h5555AAAA, 1'b1);
    endtask

    task automatic test_random_stream(int count);
        for (int k = 0; k < 4; k++)
        begin
            write_register(REG_INPUT_IS_FLOAT, k[0] | k[1]);
            write_register(REG_INPUT_IS_MONO, k[1]);
            for (int i = 0; i < count / 4; i++)
                send_sample(mode_float ? random_float_word() : $urandom,
                    ($urandom_range(3) == 0));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        mode_float = 1'b1;
        mode_mono = 1'b0;
        mismatch_count = 0;
        send_idle_pct = 31;
        recv_stall_pct = 73;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_float_extremes();
        test_int16_passthrough();
        test_random_stream(268);
        send_idle_pct = 73;
        recv_stall_pct = 31;
        test_random_stream(268);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random_stream(268);
        drain_samples();

        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
